[design/triangle_pixel_interpolator_unit_defines.svh]
// Assertion macros shared by the triangle pixel interpolator RTL.
// No dependencies; included by the files that carry assertions.
`ifndef TRIANGLE_PIXEL_INTERPOLATOR_UNIT_DEFINES_SVH
`define TRIANGLE_PIXEL_INTERPOLATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define TPI_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("tpi check failed");
`define TPI_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error("tpi bad state");
`else
`define TPI_ASSERT(lbl, clk, rst, prop)
`define TPI_NEVER(lbl, clk, rst, cond)
`endif

`endif

[design/tpi_pkg.sv]
// Shared types, codes and fixed-point helpers of the triangle pixel interpolator.
// No dependencies; imported by every module of the block.
package tpi_pkg;

  localparam int ATTR_COUNT = 14;
  localparam int FRAC_BITS  = 16;
  localparam int INT_BITS   = 32 - FRAC_BITS;
  localparam int CORNERS    = 3;
  localparam int ATTR_DEPTH = CORNERS * ATTR_COUNT;
  localparam int ATTR_AW    = $clog2(ATTR_DEPTH);
  localparam int AIDX_W     = 4;
  localparam int CMD_DEPTH  = 4;
  localparam int CMD_AW     = $clog2(CMD_DEPTH);

  localparam logic [30:0] NEAR_RESET = 31'd6554;
  localparam logic [30:0] FAR_RESET  = 31'd65536000;
  localparam logic signed [63:0] Q_ONE = 64'sd1 <<< FRAC_BITS;

  localparam logic [1:0] REQ_POS   = 2'd0;
  localparam logic [1:0] REQ_ATTR  = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  localparam logic [1:0] CULL_NONE  = 2'd0;
  localparam logic [1:0] CULL_BACK  = 2'd1;
  localparam logic [1:0] CULL_FRONT = 2'd2;

  localparam logic [1:0] CFG_CULL = 2'd0;
  localparam logic [1:0] CFG_NEAR = 2'd1;
  localparam logic [1:0] CFG_FAR  = 2'd2;

  localparam logic [2:0] ST_DRAWN       = 3'd0;
  localparam logic [2:0] ST_W_RANGE     = 3'd1;
  localparam logic [2:0] ST_NOT_COVERED = 3'd2;
  localparam logic [2:0] ST_CULLED      = 3'd3;
  localparam logic [2:0] ST_DEPTH_FAIL  = 3'd4;

  typedef enum logic [1:0] {
    CMD_POS,
    CMD_ATTR,
    CMD_QUERY
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [1:0]        slot;
    logic [AIDX_W-1:0] aidx;
    logic [31:0]       x;
    logic [31:0]       y;
    logic [31:0]       z;
    logic [31:0]       w;
    logic [31:0]       val;
  } cmd_t;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
  } div_rsp_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_CHECK,
    DV_RUN,
    DV_DONE
  } div_state_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_WCHK,
    S_EDIFF,
    S_EMUL1,
    S_EMUL2,
    S_ESUB,
    S_COVER,
    S_DIV,
    S_DIVW,
    S_MMUL,
    S_MACC,
    S_RDIV,
    S_RDIVW,
    S_DTEST,
    S_ARD,
    S_AMUL1,
    S_AQ1,
    S_AMUL2,
    S_AACC,
    S_AFIN,
    S_AOUT,
    S_FAIL
  } back_state_t;

  function automatic logic [63:0] sext64(input logic [31:0] v);
    sext64 = {{32{v[31]}}, v};
  endfunction

  function automatic logic [63:0] mag64(input logic [63:0] v);
    mag64 = v[63] ? (~v + 64'd1) : v;
  endfunction

  // clamp a 34-bit signed sum to 32 bits
  function automatic logic [31:0] sat34(input logic [33:0] v);
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
      sat34 = v[31:0];
    end else if (v[33]) begin
      sat34 = 32'h8000_0000;
    end else begin
      sat34 = 32'h7FFF_FFFF;
    end
  endfunction

  // saturating a - b
  function automatic logic [31:0] sat_sub(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] d;
    d = {a[31], a} - {b[31], b};
    if (d[32] == d[31]) begin
      sat_sub = d[31:0];
    end else if (d[32]) begin
      sat_sub = 32'h8000_0000;
    end else begin
      sat_sub = 32'h7FFF_FFFF;
    end
  endfunction

  // product scaled down by the fraction, truncated toward zero, saturated
  function automatic logic [31:0] qfix(input logic [63:0] p);
    logic [63:0] m;
    logic [63:0] s;
    logic [63:0] n;
    m = mag64(p);
    s = m >> FRAC_BITS;
    n = ~s + 64'd1;
    if (!p[63]) begin
      qfix = (s > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : s[31:0];
    end else begin
      qfix = (s > 64'h8000_0000) ? 32'h8000_0000 : n[31:0];
    end
  endfunction

endpackage

[design/tpi_cmd_fifo.sv]
// Short command queue between the front classifier and the back sequencer.
// Depends on tpi_pkg for cmd_t and the queue depth.
module tpi_cmd_fifo (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  tpi_pkg::cmd_t din,
  output logic         full,
  input  logic         pop,
  output tpi_pkg::cmd_t dout,
  output logic         valid
);
  import tpi_pkg::*;

  cmd_t              slots [CMD_DEPTH];
  logic [CMD_AW-1:0] wr_ptr;
  logic [CMD_AW-1:0] rd_ptr;
  logic [CMD_AW:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == (CMD_AW + 1)'(CMD_DEPTH));
  assign valid   = (count != '0);
  assign dout    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

[design/tpi_front.sv]
// Input side: takes request items, drops those that do nothing and packs the rest
// into commands for the queue. Depends on tpi_pkg.
module tpi_front (
  input  logic                        push,
  output logic                        full,
  input  logic [1:0]                  req_type,
  input  logic [1:0]                  vertex_slot,
  input  logic [tpi_pkg::AIDX_W-1:0]  attr_index,
  input  logic signed [31:0]          pos_x,
  input  logic signed [31:0]          pos_y,
  input  logic signed [31:0]          pos_z,
  input  logic signed [31:0]          pos_w,
  input  logic signed [31:0]          attr_value,
  input  logic signed [31:0]          depth_in,
  input  logic                        fifo_full,
  output logic                        cmd_push,
  output tpi_pkg::cmd_t               cmd
);
  import tpi_pkg::*;

  logic keep;
  logic slot_ok;

  assign full    = fifo_full;
  assign slot_ok = (vertex_slot < 2'(CORNERS));

  always_comb begin
    cmd.slot = vertex_slot;
    cmd.aidx = attr_index;
    cmd.x    = pos_x;
    cmd.y    = pos_y;
    cmd.z    = pos_z;
    cmd.w    = pos_w;
    cmd.val  = depth_in;
    cmd.kind = CMD_QUERY;
    keep     = 1'b0;
    case (req_type)
      REQ_POS: begin
        cmd.kind = CMD_POS;
        keep     = slot_ok;
      end
      REQ_ATTR: begin
        cmd.kind = CMD_ATTR;
        cmd.val  = attr_value;
        keep     = slot_ok && (attr_index < AIDX_W'(ATTR_COUNT));
      end
      REQ_QUERY: begin
        cmd.kind = CMD_QUERY;
        keep     = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  // ignored items are still transferred, they just never reach the queue
  assign cmd_push = push && !fifo_full && keep;

endmodule

[design/tpi_div.sv]
// Fixed-point divider: num * 2^F / den, restoring, one quotient bit per cycle,
// saturated to 32 bits. Depends on tpi_pkg and the assertion macro header.
`include "triangle_pixel_interpolator_unit_defines.svh"
module tpi_div (
  input  logic              clk,
  input  logic              rst,
  input  tpi_pkg::div_req_t req,
  output tpi_pkg::div_rsp_t rsp
);
  import tpi_pkg::*;

  div_state_t  state;
  div_state_t  state_next;
  logic [63:0] nmag;
  logic [63:0] dmag;
  logic [64:0] dmag_ext;
  logic        neg;
  logic [64:0] rem;
  logic [31:0] sh;
  logic [32:0] quo;
  logic [4:0]  cnt;
  logic [64:0] trial;
  logic        fits;
  logic        ovf;
  logic [32:0] quo_neg;

  assign dmag_ext = {1'b0, dmag};
  assign trial    = {rem[63:0], sh[31]};
  assign fits     = (trial >= dmag_ext);
  // integer part of the quotient would not fit in the result
  assign ovf      = ({{INT_BITS{1'b0}}, nmag} >= {dmag, {INT_BITS{1'b0}}});
  assign quo_neg  = ~quo + 33'd1;

  always_comb begin
    state_next = state;
    case (state)
      DV_IDLE:  if (req.start) state_next = DV_CHECK;
      DV_CHECK: begin
        if (dmag == '0 || ovf) begin
          state_next = DV_DONE;
        end else begin
          state_next = DV_RUN;
        end
      end
      DV_RUN:   if (cnt == 5'd31) state_next = DV_DONE;
      DV_DONE:  state_next = DV_IDLE;
      default:  state_next = DV_IDLE;
    endcase
  end

  always_comb begin
    rsp.done = (state == DV_DONE);
    if (neg) begin
      rsp.quo = (quo > 33'h0_8000_0000) ? 32'h8000_0000 : quo_neg[31:0];
    end else begin
      rsp.quo = (quo > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : quo[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      DV_IDLE: begin
        if (req.start) begin
          nmag <= mag64(req.num);
          dmag <= mag64(req.den);
          neg  <= req.num[63] ^ req.den[63];
        end
      end
      DV_CHECK: begin
        cnt <= '0;
        if (dmag == '0) begin
          // divide by zero gives the largest positive value
          quo <= 33'h0_7FFF_FFFF;
          neg <= 1'b0;
        end else if (ovf) begin
          quo <= 33'h1_0000_0000;
        end else begin
          quo <= '0;
          rem <= 65'(nmag >> INT_BITS);
          sh  <= {nmag[INT_BITS-1:0], {FRAC_BITS{1'b0}}};
        end
      end
      DV_RUN: begin
        cnt <= cnt + 5'd1;
        sh  <= {sh[30:0], 1'b0};
        quo <= {quo[31:0], fits};
        rem <= fits ? (trial - dmag_ext) : trial;
      end
      default: begin
      end
    endcase
  end

  `TPI_ASSERT(a_div_start_idle, clk, rst, req.start |-> (state == DV_IDLE))
  `TPI_ASSERT(a_div_rem_bound, clk, rst, (state == DV_RUN) |-> (rem < dmag_ext))
  `TPI_ASSERT(a_div_done_pulse, clk, rst, rsp.done |=> !rsp.done)

endmodule

[design/tpi_back.sv]
// Back sequencer: vertex storage, configuration registers, edge and weight math
// on one shared multiplier and the divider, and the result register.
// Depends on tpi_pkg, tpi_div and the assertion macro header.
`include "triangle_pixel_interpolator_unit_defines.svh"
module tpi_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [1:0]                 cfg_index,
  input  logic [30:0]                cfg_data,
  input  logic                       cmd_valid,
  input  tpi_pkg::cmd_t              cmd,
  output logic                       cmd_pop,
  output logic                       empty,
  input  logic                       pop,
  output logic [2:0]                 status,
  output logic signed [31:0]         depth_out,
  output logic signed [31:0]         persp_w_out,
  output logic [tpi_pkg::AIDX_W-1:0] attr_index_out,
  output logic signed [31:0]         attr_out,
  output logic                       last
);
  import tpi_pkg::*;

  back_state_t state;
  back_state_t state_next;

  logic [1:0]  cull_mode;
  logic [30:0] near_w_limit;
  logic [30:0] far_w_limit;

  logic [31:0] vx [CORNERS];
  logic [31:0] vy [CORNERS];
  logic [31:0] vz [CORNERS];
  logic [31:0] vw [CORNERS];

  logic [31:0] attr_mem [ATTR_DEPTH];
  logic [31:0] mem_rdata;
  logic [ATTR_AW-1:0] mem_raddr;
  logic [ATTR_AW-1:0] mem_waddr;
  logic               mem_we;

  logic [31:0] qx;
  logic [31:0] qy;
  logic [31:0] qdepth;

  logic [1:0]  k;
  logic [1:0]  i;
  logic [3:0]  j;
  logic        grp;
  logic [AIDX_W-1:0] aidx;

  logic signed [31:0] ax;
  logic signed [31:0] ay;
  logic signed [31:0] bx;
  logic signed [31:0] by;
  logic signed [63:0] prod;
  logic signed [63:0] prod2;
  logic [63:0] cr [4];
  logic [31:0] wt [CORNERS];
  logic [31:0] rz [CORNERS];
  logic [31:0] rw [CORNERS];
  logic [33:0] acc;
  logic signed [31:0] tq;
  logic [31:0] depth;
  logic [31:0] persp;
  logic [2:0]  fail_status;

  logic        out_valid;
  logic        out_free;
  logic        out_load;

  div_req_t    div_req;
  div_rsp_t    div_rsp;

  logic [31:0] sel_px;
  logic [31:0] sel_py;
  logic [31:0] sel_ox;
  logic [31:0] sel_oy;
  logic [31:0] sel_fx;
  logic [31:0] sel_fy;
  logic [31:0] w_cur;
  logic        w_bad;
  logic [2:0]  e_neg;
  logic        all_neg;
  logic        none_neg;
  logic        cov_bad;
  logic        cull_bad;
  logic        depth_bad;
  logic [2:0]  fail_code;
  logic [31:0] qp;
  logic [31:0] acc_sat;

  tpi_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign empty    = !out_valid;
  assign out_free = !out_valid || pop;
  assign qp       = qfix(prod);
  assign acc_sat  = sat34(acc);

  // corner w limits
  always_comb begin
    case (i)
      2'd0:    w_cur = vw[0];
      2'd1:    w_cur = vw[1];
      default: w_cur = vw[2];
    endcase
  end
  assign w_bad = ($signed(w_cur) < $signed({1'b0, near_w_limit}))
              || ($signed(w_cur) > $signed({1'b0, far_w_limit}));

  // operands of the edge function k; the last one is the total area
  always_comb begin
    sel_px = qx;
    sel_py = qy;
    case (k)
      2'd0: begin
        sel_ox = vx[1]; sel_oy = vy[1]; sel_fx = vx[2]; sel_fy = vy[2];
      end
      2'd1: begin
        sel_ox = vx[2]; sel_oy = vy[2]; sel_fx = vx[0]; sel_fy = vy[0];
      end
      2'd2: begin
        sel_ox = vx[0]; sel_oy = vy[0]; sel_fx = vx[1]; sel_fy = vy[1];
      end
      default: begin
        sel_px = vx[2]; sel_py = vy[2];
        sel_ox = vx[0]; sel_oy = vy[0]; sel_fx = vx[1]; sel_fy = vy[1];
      end
    endcase
  end

  assign e_neg     = {cr[2][63], cr[1][63], cr[0][63]};
  assign all_neg   = &e_neg;
  assign none_neg  = ~|e_neg;
  assign cov_bad   = !(all_neg || none_neg) || (cr[3] == '0);
  assign cull_bad  = ((cull_mode == CULL_BACK) && all_neg)
                  || ((cull_mode == CULL_FRONT) && none_neg);
  assign depth_bad = ($signed(depth) > $signed(qdepth));

  always_comb begin
    case (state)
      S_WCHK:  fail_code = ST_W_RANGE;
      S_COVER: fail_code = cov_bad ? ST_NOT_COVERED : ST_CULLED;
      default: fail_code = ST_DEPTH_FAIL;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (cmd_valid && cmd.kind == CMD_QUERY) state_next = S_WCHK;
      S_WCHK: begin
        if (w_bad) begin
          state_next = S_FAIL;
        end else if (i == 2'd2) begin
          state_next = S_EDIFF;
        end
      end
      S_EDIFF: state_next = S_EMUL1;
      S_EMUL1: state_next = S_EMUL2;
      S_EMUL2: state_next = S_ESUB;
      S_ESUB:  state_next = (k == 2'd3) ? S_COVER : S_EDIFF;
      S_COVER: state_next = (cov_bad || cull_bad) ? S_FAIL : S_DIV;
      S_DIV:   state_next = S_DIVW;
      S_DIVW: begin
        if (div_rsp.done) begin
          state_next = (j == 4'd8) ? S_MMUL : S_DIV;
        end
      end
      S_MMUL:  state_next = S_MACC;
      S_MACC:  state_next = (i == 2'd2) ? S_RDIV : S_MMUL;
      S_RDIV:  state_next = S_RDIVW;
      S_RDIVW: begin
        if (div_rsp.done) begin
          state_next = grp ? S_DTEST : S_MMUL;
        end
      end
      S_DTEST: state_next = depth_bad ? S_FAIL : S_ARD;
      S_ARD:   state_next = S_AMUL1;
      S_AMUL1: state_next = S_AQ1;
      S_AQ1:   state_next = S_AMUL2;
      S_AMUL2: state_next = S_AACC;
      S_AACC:  state_next = (i == 2'd2) ? S_AFIN : S_ARD;
      S_AFIN:  state_next = S_AOUT;
      S_AOUT: begin
        if (out_free) begin
          state_next = (aidx == AIDX_W'(ATTR_COUNT - 1)) ? S_IDLE : S_ARD;
        end
      end
      S_FAIL:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    cmd_pop     = (state == S_IDLE) && cmd_valid;
    out_load    = ((state == S_AOUT) || (state == S_FAIL)) && out_free;
    mem_raddr   = ATTR_AW'(i) * ATTR_AW'(ATTR_COUNT) + ATTR_AW'(aidx);
    mem_waddr   = ATTR_AW'(cmd.slot) * ATTR_AW'(ATTR_COUNT) + ATTR_AW'(cmd.aidx);
    mem_we      = cmd_pop && (cmd.kind == CMD_ATTR);
    div_req.start = (state == S_DIV) || (state == S_RDIV);
    div_req.num = Q_ONE;
    div_req.den = sext64(acc_sat);
    if (state == S_DIV) begin
      case (j)
        4'd0: begin div_req.num = cr[0]; div_req.den = cr[3]; end
        4'd1: begin div_req.num = cr[1]; div_req.den = cr[3]; end
        4'd2: begin div_req.num = cr[2]; div_req.den = cr[3]; end
        4'd3: div_req.den = sext64(vz[0]);
        4'd4: div_req.den = sext64(vz[1]);
        4'd5: div_req.den = sext64(vz[2]);
        4'd6: div_req.den = sext64(vw[0]);
        4'd7: div_req.den = sext64(vw[1]);
        default: div_req.den = sext64(vw[2]);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cull_mode    <= CULL_NONE;
      near_w_limit <= NEAR_RESET;
      far_w_limit  <= FAR_RESET;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        case (cfg_index)
          CFG_CULL: cull_mode    <= cfg_data[1:0];
          CFG_NEAR: near_w_limit <= cfg_data;
          CFG_FAR:  far_w_limit  <= cfg_data;
          default: begin
          end
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      attr_mem[mem_waddr] <= cmd.val;
    end
    mem_rdata <= attr_mem[mem_raddr];
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state_next == S_FAIL && state != S_FAIL) begin
      fail_status <= fail_code;
    end
    case (state)
      S_IDLE: begin
        i <= '0;
        if (cmd_pop) begin
          if (cmd.kind == CMD_POS) begin
            vx[cmd.slot] <= cmd.x;
            vy[cmd.slot] <= cmd.y;
            vz[cmd.slot] <= cmd.z;
            vw[cmd.slot] <= cmd.w;
          end
          qx     <= cmd.x;
          qy     <= cmd.y;
          qdepth <= cmd.val;
        end
      end
      S_WCHK: begin
        i <= i + 2'd1;
        k <= '0;
      end
      S_EDIFF: begin
        ax <= sat_sub(sel_px, sel_ox);
        ay <= sat_sub(sel_py, sel_oy);
        bx <= sat_sub(sel_fx, sel_ox);
        by <= sat_sub(sel_fy, sel_oy);
      end
      S_EMUL1: prod  <= ax * by;
      S_EMUL2: prod2 <= ay * bx;
      S_ESUB: begin
        cr[k] <= prod - prod2;
        k     <= k + 2'd1;
      end
      S_COVER: j <= '0;
      S_DIVW: begin
        if (div_rsp.done) begin
          case (j)
            4'd0: wt[0] <= div_rsp.quo;
            4'd1: wt[1] <= div_rsp.quo;
            4'd2: wt[2] <= div_rsp.quo;
            4'd3: rz[0] <= div_rsp.quo;
            4'd4: rz[1] <= div_rsp.quo;
            4'd5: rz[2] <= div_rsp.quo;
            4'd6: rw[0] <= div_rsp.quo;
            4'd7: rw[1] <= div_rsp.quo;
            default: rw[2] <= div_rsp.quo;
          endcase
          j   <= j + 4'd1;
          i   <= '0;
          grp <= 1'b0;
          acc <= '0;
        end
      end
      S_MMUL: prod <= $signed(wt[i]) * $signed(grp ? rw[i] : rz[i]);
      S_MACC: begin
        acc <= acc + {{2{qp[31]}}, qp};
        i   <= (i == 2'd2) ? 2'd0 : i + 2'd1;
      end
      S_RDIVW: begin
        if (div_rsp.done) begin
          if (grp) begin
            persp <= div_rsp.quo;
          end else begin
            depth <= div_rsp.quo;
          end
          grp <= 1'b1;
          acc <= '0;
          i   <= '0;
        end
      end
      S_DTEST: begin
        aidx <= '0;
        acc  <= '0;
        i    <= '0;
      end
      S_AMUL1: prod <= $signed(mem_rdata) * $signed(rw[i]);
      S_AQ1:   tq   <= qp;
      S_AMUL2: prod <= tq * $signed(wt[i]);
      S_AACC: begin
        acc <= acc + {{2{qp[31]}}, qp};
        i   <= (i == 2'd2) ? 2'd0 : i + 2'd1;
      end
      S_AFIN:  prod <= $signed(acc_sat) * $signed(persp);
      S_AOUT: begin
        if (out_free) begin
          aidx <= aidx + 1'b1;
          acc  <= '0;
          i    <= '0;
        end
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == S_AOUT) begin
        status         <= ST_DRAWN;
        depth_out      <= depth;
        persp_w_out    <= persp;
        attr_index_out <= aidx;
        attr_out       <= qp;
        last           <= (aidx == AIDX_W'(ATTR_COUNT - 1));
      end else begin
        status         <= fail_status;
        depth_out      <= '0;
        persp_w_out    <= '0;
        attr_index_out <= '0;
        attr_out       <= '0;
        last           <= 1'b1;
      end
    end
  end

  `TPI_ASSERT(a_out_no_overwrite, clk, rst, out_load |-> (!out_valid || pop))
  `TPI_ASSERT(a_fail_is_last, clk, rst, (out_valid && status != ST_DRAWN) |-> last)
  `TPI_ASSERT(a_pop_in_idle, clk, rst, cmd_pop |-> (state == S_IDLE))
  `TPI_NEVER(a_aidx_range, clk, rst, (state == S_AOUT) && (aidx > AIDX_W'(ATTR_COUNT - 1)))

endmodule

[design/triangle_pixel_interpolator_unit.sv]
// Triangle pixel interpolator: perspective-correct barycentric interpolation of one
// triangle at one pixel per query.
// Usage:
//   request side is a queue: drive the item fields with push high; the item is taken
//   on an edge where full is low. Load items store a corner position or one corner
//   attribute and produce no result; pixel queries produce results.
//   result side is a queue: while empty is low the oldest result is on the result
//   ports; raise pop to take it. A failed query gives one result with its status and
//   last set; a drawn query gives fourteen results, one per attribute, last on the end.
//   configuration writes (cull mode, near w, far w) take effect on the edge with
//   cfg_write high; write them only while the block is idle.
// Timing: a four-entry command queue sits between the input and the sequencer, so
//   loads are taken at one per cycle until it fills. The sequencer takes loads from
//   the queue only while it is idle. A drawn query is paced by the divider (eleven
//   divisions, one quotient bit per cycle) and the single shared multiplier. Culled
//   or uncovered queries end before any division.
// Reset: rst clears the queues, the sequencer and the configuration to its defaults;
//   vertex data is undefined until loaded. A stalled result side holds the sequencer
//   at its next result while the command queue keeps filling.
module triangle_pixel_interpolator_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [1:0]                  cfg_index,
  input  logic [30:0]                 cfg_data,
  input  logic                        push,
  output logic                        full,
  input  logic [1:0]                  req_type,
  input  logic [1:0]                  vertex_slot,
  input  logic [tpi_pkg::AIDX_W-1:0]  attr_index,
  input  logic signed [31:0]          pos_x,
  input  logic signed [31:0]          pos_y,
  input  logic signed [31:0]          pos_z,
  input  logic signed [31:0]          pos_w,
  input  logic signed [31:0]          attr_value,
  input  logic signed [31:0]          depth_in,
  output logic                        empty,
  input  logic                        pop,
  output logic [2:0]                  status,
  output logic signed [31:0]          depth_out,
  output logic signed [31:0]          persp_w_out,
  output logic [tpi_pkg::AIDX_W-1:0]  attr_index_out,
  output logic signed [31:0]          attr_out,
  output logic                        last
);
  import tpi_pkg::*;

  logic fifo_full;
  logic cmd_push;
  cmd_t cmd_in;
  cmd_t cmd_out;
  logic cmd_valid;
  logic cmd_pop;

  tpi_front u_front (
    .push        (push),
    .full        (full),
    .req_type    (req_type),
    .vertex_slot (vertex_slot),
    .attr_index  (attr_index),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .pos_w       (pos_w),
    .attr_value  (attr_value),
    .depth_in    (depth_in),
    .fifo_full   (fifo_full),
    .cmd_push    (cmd_push),
    .cmd         (cmd_in)
  );

  tpi_cmd_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (fifo_full),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .valid (cmd_valid)
  );

  tpi_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd_out),
    .cmd_pop        (cmd_pop),
    .empty          (empty),
    .pop            (pop),
    .status         (status),
    .depth_out      (depth_out),
    .persp_w_out    (persp_w_out),
    .attr_index_out (attr_index_out),
    .attr_out       (attr_out),
    .last           (last)
  );

endmodule

[tb/sv/tb_triangle_pixel_interpolator_unit.sv]
`timescale 1ns / 100ps
// Testbench for triangle_pixel_interpolator_unit: directed and random loads and pixel queries
// checked against a fixed-point interpolation predictor. Depends on tpi_pkg.
module tb_triangle_pixel_interpolator_unit;
  import tpi_pkg::*;

  localparam int    QONE       = 65536;
  localparam int    WDOG_LIMIT = 20000;
  localparam int    DRAIN_WAIT = 60;
  localparam longint I32_MAX   = 64'sd2147483647;
  localparam longint I32_MIN   = -64'sd2147483648;

  typedef struct {
    logic [1:0]  req;
    logic [1:0]  slot;
    logic [3:0]  aidx;
    logic [31:0] x, y, z, w, val, din;
  } pix_req_t;

  typedef struct {
    logic [2:0]  st;
    logic [31:0] d, pw;
    logic [3:0]  ai;
    logic [31:0] av;
    logic        lst;
  } pix_res_t;

  logic        clk, rst;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [30:0] cfg_data;
  logic        push, full, empty, pop;
  logic [1:0]  req_type, vertex_slot;
  logic [3:0]  attr_index;
  logic signed [31:0] pos_x, pos_y, pos_z, pos_w, attr_value, depth_in;
  logic [2:0]  status;
  logic signed [31:0] depth_out, persp_w_out, attr_out;
  logic [3:0]  attr_index_out;
  logic        last;

  // predictor copy of the block's state
  logic [31:0] corner_pos [12];
  logic [31:0] corner_attr [3*ATTR_COUNT];
  logic [1:0]  cull_sel;
  logic [30:0] near_lim, far_lim;

  pix_res_t pending_results[$];
  int errors, results_seen, items_sent, queries_sent, drawn_seen;
  int wdog;
  bit tx_idle_en, rx_idle_en;
  int rx_hold;

  triangle_pixel_interpolator_unit i_dut (.*);

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  function automatic longint sat32(longint v);
    if (v > I32_MAX) return I32_MAX;
    if (v < I32_MIN) return I32_MIN;
    return v;
  endfunction

  function automatic longint sx(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  // num * 2^F / den, truncated toward zero, saturated
  function automatic longint fx_div(longint num, longint den);
    logic [63:0] un, ud, q, r;
    bit neg;
    un = (num < 0) ? 64'(-num) : 64'(num);
    ud = (den < 0) ? 64'(-den) : 64'(den);
    neg = (num < 0) != (den < 0);
    if (ud == 0) return I32_MAX;
    q = un / ud;
    r = un % ud;
    if (q >= (64'd1 << (32 - FRAC_BITS))) begin
      q = 64'd1 << 32;
    end else begin
      for (int b = 0; b < FRAC_BITS; b++) begin
        r = r << 1;
        q = q << 1;
        if (r >= ud) begin
          r = r - ud;
          q[0] = 1'b1;
        end
      end
    end
    return sat32(neg ? -longint'(q) : longint'(q));
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    longint p;
    logic [63:0] m;
    p = a * b;
    m = ((p < 0) ? 64'(-p) : 64'(p)) >> FRAC_BITS;
    return sat32(p < 0 ? -longint'(m) : longint'(m));
  endfunction

  function automatic longint cpos(int c, int comp);
    return sx(corner_pos[c*4 + comp]);
  endfunction

  function automatic pix_res_t fail_res(logic [2:0] st);
    pix_res_t r;
    r = '{st: st, d: 0, pw: 0, ai: 0, av: 0, lst: 1'b1};
    return r;
  endfunction

  // append one expected result at the tail of the queue
  function automatic void expect_res(pix_res_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  // updates the state for loads and queues the expected results of a query
  function automatic void interpolate_pixel(pix_req_t it);
    longint e[3], wt[3], rz[3], rw[3];
    longint tot, sz, sw, dep, psp, px, py, ox, oy, s, v;
    int negs;
    pix_res_t r;
    sz = 0; sw = 0; negs = 0;
    px = sx(it.x); py = sx(it.y);
    if (it.req == REQ_POS) begin
      if (it.slot < 3) begin
        corner_pos[it.slot*4 + 0] = it.x;
        corner_pos[it.slot*4 + 1] = it.y;
        corner_pos[it.slot*4 + 2] = it.z;
        corner_pos[it.slot*4 + 3] = it.w;
      end
      return;
    end
    if (it.req == REQ_ATTR) begin
      if (it.slot < 3 && it.aidx < ATTR_COUNT) corner_attr[it.slot*ATTR_COUNT + it.aidx] = it.val;
      return;
    end
    if (it.req != REQ_QUERY) return;
    queries_sent++;
    for (int i = 0; i < 3; i++) begin
      if (cpos(i, 3) < longint'(near_lim) || cpos(i, 3) > longint'(far_lim)) begin
        expect_res(fail_res(ST_W_RANGE));
        return;
      end
    end
    for (int i = 0; i < 3; i++) begin
      ox = cpos((i+1)%3, 0);
      oy = cpos((i+1)%3, 1);
      e[i] = sat32(px - ox) * sat32(cpos((i+2)%3, 1) - oy)
           - sat32(py - oy) * sat32(cpos((i+2)%3, 0) - ox);
      if (e[i] < 0) negs++;
    end
    tot = sat32(cpos(2,0) - cpos(0,0)) * sat32(cpos(1,1) - cpos(0,1))
        - sat32(cpos(2,1) - cpos(0,1)) * sat32(cpos(1,0) - cpos(0,0));
    if ((negs != 0 && negs != 3) || tot == 0) begin
      expect_res(fail_res(ST_NOT_COVERED));
      return;
    end
    if ((cull_sel == CULL_BACK && negs == 3) || (cull_sel == CULL_FRONT && negs == 0)) begin
      expect_res(fail_res(ST_CULLED));
      return;
    end
    for (int i = 0; i < 3; i++) begin
      wt[i] = fx_div(e[i], tot);
      rz[i] = fx_div(QONE, cpos(i, 2));
      rw[i] = fx_div(QONE, cpos(i, 3));
      sz += fx_mul(wt[i], rz[i]);
      sw += fx_mul(wt[i], rw[i]);
    end
    dep = fx_div(QONE, sat32(sz));
    psp = fx_div(QONE, sat32(sw));
    if (dep > sx(it.din)) begin
      expect_res(fail_res(ST_DEPTH_FAIL));
      return;
    end
    for (int a = 0; a < ATTR_COUNT; a++) begin
      s = 0;
      for (int i = 0; i < 3; i++) begin
        v = sx(corner_attr[i*ATTR_COUNT + a]);
        s += fx_mul(fx_mul(v, rw[i]), wt[i]);
      end
      r.st = ST_DRAWN;
      r.d = dep[31:0];
      r.pw = psp[31:0];
      r.ai = a[3:0];
      r.av = 32'(fx_mul(sat32(s), psp));
      r.lst = (a == ATTR_COUNT - 1);
      expect_res(r);
    end
  endfunction

  // ---------------- result side ----------------
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      pop <= 1'b0;
    end else begin
      pop <= !(rx_idle_en && $urandom_range(0, 99) < 12);
    end
  end

  always @(posedge clk) begin
    pix_res_t got, want;
    if (!rst && pop && !empty) begin
      got = '{st: status, d: depth_out, pw: persp_w_out, ai: attr_index_out,
              av: attr_out, lst: last};
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result st=%0d d=%h pw=%h ai=%0d av=%h last=%b",
                 $time, got.st, got.d, got.pw, got.ai, got.av, got.lst);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (want.st == ST_DRAWN && got.st == ST_DRAWN) drawn_seen++;
        if (got.st !== want.st || got.d !== want.d || got.pw !== want.pw ||
            got.ai !== want.ai || got.av !== want.av || got.lst !== want.lst) begin
          $display("%0t: mismatch expected st=%0d d=%h pw=%h ai=%0d av=%h last=%b",
                   $time, want.st, want.d, want.pw, want.ai, want.av, want.lst);
          $display("%0t:          actual   st=%0d d=%h pw=%h ai=%0d av=%h last=%b",
                   $time, got.st, got.d, got.pw, got.ai, got.av, got.lst);
          errors++;
        end
      end
    end
  end

  // watchdog: cycles without any transfer
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      wdog <= 0;
    end else begin
      wdog <= wdog + 1;
      if (wdog > WDOG_LIMIT) begin
        $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // ---------------- request side ----------------
  task automatic send_item(pix_req_t it);
    if (tx_idle_en && $urandom_range(0, 99) < 12) begin
      @(negedge clk) push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    req_type <= it.req;
    vertex_slot <= it.slot;
    attr_index <= it.aidx;
    pos_x <= it.x; pos_y <= it.y; pos_z <= it.z; pos_w <= it.w;
    attr_value <= it.val;
    depth_in <= it.din;
    push <= 1'b1;
    do @(posedge clk); while (full);
    interpolate_pixel(it);
    if (it.req != 2'd3 && !(it.req != REQ_QUERY && it.slot == 2'd3)) items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk) push <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    // trailing loads may still be in the command queue
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic set_config(logic [1:0] cm, logic [30:0] nr, logic [30:0] fr);
    wait_drained();
    cfg_write <= 1'b1; cfg_index <= CFG_CULL; cfg_data <= {29'd0, cm};
    @(negedge clk) cfg_index <= CFG_NEAR; cfg_data <= nr;
    @(negedge clk) cfg_index <= CFG_FAR; cfg_data <= fr;
    @(negedge clk) cfg_write <= 1'b0;
    cull_sel = cm; near_lim = nr; far_lim = fr;
  endtask

  function automatic pix_req_t pos_item(int slot, int x, int y, int z, int w);
    pix_req_t it;
    it = '{req: REQ_POS, slot: slot[1:0], aidx: 0, x: x, y: y, z: z, w: w,
           val: $urandom, din: $urandom};
    return it;
  endfunction

  function automatic pix_req_t attr_item(int slot, int idx, logic [31:0] v);
    pix_req_t it;
    it = '{req: REQ_ATTR, slot: slot[1:0], aidx: idx[3:0], x: $urandom, y: $urandom,
           z: $urandom, w: $urandom, val: v, din: $urandom};
    return it;
  endfunction

  function automatic pix_req_t query_item(int x, int y, logic [31:0] din);
    pix_req_t it;
    it = '{req: REQ_QUERY, slot: 2'($urandom), aidx: 4'($urandom), x: x, y: y,
           z: $urandom, w: $urandom, val: $urandom, din: din};
    return it;
  endfunction

  function automatic int rnd_coord();
    return int'($urandom_range(0, 32'h80_0000)) - 32'h40_0000;
  endfunction

  task automatic load_all_attrs();
    for (int s = 0; s < 3; s++)
      for (int a = 0; a < ATTR_COUNT; a++) send_item(attr_item(s, a, $urandom));
  endtask

  task automatic load_rand_triangle();
    int z, w;
    for (int s = 0; s < 3; s++) begin
      z = ($urandom_range(0, 19) == 0) ? int'($urandom_range(0, 2)) - 1
                                       : int'($urandom_range(32'h1000, 32'h100_0000));
      w = ($urandom_range(0, 15) == 0) ? int'($urandom)
                                       : int'($urandom_range(32'h8000, 32'h40_0000));
      send_item(pos_item(s, rnd_coord(), rnd_coord(), z, w));
    end
  endtask

  // ---------------- tests ----------------
  task automatic test_directed();
    send_item(pos_item(0, 0, 0, QONE, QONE));
    send_item(pos_item(1, 10*QONE, 0, 2*QONE, 2*QONE));
    send_item(pos_item(2, 0, 10*QONE, 3*QONE, 4*QONE));
    load_all_attrs();
    send_item(attr_item(0, 0, 32'h7FFF_FFFF));
    send_item(attr_item(1, 0, 32'h8000_0000));
    // ignored: bad slot, bad attribute numbers, reserved request
    send_item(attr_item(3, 1, 32'h1234_5678));
    send_item(attr_item(0, 14, 32'hFFFF_FFFF));
    send_item(attr_item(2, 15, 32'h0));
    send_item('{req: 2'd3, slot: 0, aidx: 0, x: QONE, y: QONE, z: 0, w: 0, val: 0, din: 0});
    send_item(pos_item(3, 0, 0, 0, 0));
    send_item(query_item(2*QONE, 2*QONE, 32'h7FFF_FFFF));
    send_item(query_item(20*QONE, 20*QONE, 32'h7FFF_FFFF));
    send_item(query_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    send_item(query_item(QONE, QONE, 32'h8000_0000));
    send_item(query_item(0, 0, 32'h7FFF_FFFF));
    // division by zero through a zero corner depth
    send_item(pos_item(1, 10*QONE, 0, 0, 2*QONE));
    send_item(query_item(3*QONE, QONE, 32'h7FFF_FFFF));
    // w below near limit, then a degenerate triangle
    send_item(pos_item(1, 10*QONE, 0, 2*QONE, 0));
    send_item(query_item(QONE, QONE, 32'h7FFF_FFFF));
    send_item(pos_item(1, 5*QONE, 5*QONE, 2*QONE, 2*QONE));
    send_item(pos_item(2, 10*QONE, 10*QONE, 3*QONE, 4*QONE));
    send_item(query_item(QONE, QONE, 32'h7FFF_FFFF));
  endtask

  task automatic test_cull_and_limits();
    for (int m = 0; m < 4; m++) begin
      set_config(m[1:0], NEAR_RESET, FAR_RESET);
      send_item(pos_item(1, 10*QONE, 0, 2*QONE, 2*QONE));
      send_item(pos_item(2, 0, 10*QONE, 3*QONE, 4*QONE));
      send_item(query_item(2*QONE, 3*QONE, 32'h7FFF_FFFF));
      // opposite winding
      send_item(pos_item(1, 0, 10*QONE, 2*QONE, 2*QONE));
      send_item(pos_item(2, 10*QONE, 0, 3*QONE, 4*QONE));
      send_item(query_item(3*QONE, 2*QONE, 32'h7FFF_FFFF));
    end
    set_config(CULL_NONE, 31'd0, 31'h7FFF_FFFF);
    send_item(query_item(QONE, QONE, 32'h7FFF_FFFF));
    set_config(CULL_NONE, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_item(query_item(QONE, QONE, 32'h7FFF_FFFF));
    set_config(CULL_NONE, 31'd0, 31'd0);
    send_item(query_item(QONE, QONE, 32'h7FFF_FFFF));
  endtask

  task automatic test_random(int count);
    int nq;
    while (items_sent < count) begin
      if (items_sent % 120 < 8 && $urandom_range(0, 3) == 0) begin
        set_config(2'($urandom_range(0, 3)),
                   ($urandom_range(0, 2) == 0) ? 31'($urandom) : NEAR_RESET,
                   ($urandom_range(0, 2) == 0) ? 31'h7FFF_FFFF : FAR_RESET);
      end
      tx_idle_en = (items_sent < count/2);
      rx_idle_en = (items_sent < count/2);
      if ($urandom_range(0, 99) < 85) begin
        load_rand_triangle();
        repeat ($urandom_range(0, 6))
          send_item(attr_item($urandom_range(0, 2), $urandom_range(0, ATTR_COUNT-1), $urandom));
        nq = $urandom_range(1, 5);
        repeat (nq)
          send_item(query_item(rnd_coord(), rnd_coord(),
                               ($urandom_range(0, 3) == 0) ? $urandom : 32'h7FFF_FFFF));
      end else begin
        send_item('{req: 2'($urandom), slot: 2'($urandom), aidx: 4'($urandom), x: $urandom,
                    y: $urandom, z: $urandom, w: $urandom, val: $urandom, din: $urandom});
      end
    end
    tx_idle_en = 1;
    rx_idle_en = 1;
  endtask

  task automatic test_backpressure();
    set_config(CULL_NONE, NEAR_RESET, FAR_RESET);
    send_item(pos_item(0, 0, 0, QONE, QONE));
    send_item(pos_item(1, 10*QONE, 0, 2*QONE, 2*QONE));
    send_item(pos_item(2, 0, 10*QONE, 3*QONE, 4*QONE));
    rx_hold = 3000;
    for (int k = 0; k < 6; k++) begin
      send_item(query_item((1 + k)*QONE, QONE, 32'h7FFF_FFFF));
      send_item(attr_item(k % 3, k, $urandom));
    end
    // sender pauses until every result is back
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 0; cfg_index = 0; cfg_data = 0;
    push = 0; req_type = 0; vertex_slot = 0; attr_index = 0;
    pos_x = 0; pos_y = 0; pos_z = 0; pos_w = 0; attr_value = 0; depth_in = 0;
    pop = 0; rx_hold = 0; wdog = 0;
    tx_idle_en = 1; rx_idle_en = 1;
    errors = 0; results_seen = 0; items_sent = 0; queries_sent = 0; drawn_seen = 0;
    cull_sel = CULL_NONE; near_lim = NEAR_RESET; far_lim = FAR_RESET;
    foreach (corner_pos[i]) corner_pos[i] = 0;
    foreach (corner_attr[i]) corner_attr[i] = 0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_cull_and_limits();
    test_backpressure();
    test_random(items_sent + 450);

    wait_drained();
    repeat (100) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      errors++;
    end
    $display("run covered %0d items with %0d pixel queries, %0d results (%0d drawn)",
             items_sent, queries_sent, results_seen, drawn_seen);
    $display("cull modes, w limits, stalls on both sides; %0d errors", errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/tpi_pkg.sv
design/tpi_cmd_fifo.sv
design/tpi_front.sv
design/tpi_div.sv
design/tpi_back.sv
design/triangle_pixel_interpolator_unit.sv
tb/sv/tb_triangle_pixel_interpolator_unit.sv
